>>> hdl/sjis_to_euc_stream_macros.svh
// assertion macros shared by the queue and output modules
`ifndef SJIS_TO_EUC_STREAM_MACROS_SVH
`define SJIS_TO_EUC_STREAM_MACROS_SVH

// same-cycle implication, checked outside reset
`define S2E_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("s2e assertion failed");

// next-cycle implication, checked outside reset
`define S2E_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("s2e assertion failed");

`endif

>>> hdl/s2e_pkg.sv
package s2e_pkg;

  localparam int LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // up to two output bytes produced by one source byte
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
  } entry_t;

endpackage

>>> hdl/s2e_src_if.sv
interface s2e_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

>>> hdl/s2e_out_if.sv
interface s2e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> hdl/s2e_front.sv
module s2e_front (
  input  logic                       clk,
  input  logic                       rst,
  s2e_src_if.sink                    src,
  input  logic                       cfg_we,
  input  logic [s2e_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                       q_full,
  output logic                       push,
  output s2e_pkg::entry_t            push_entry
);

  localparam logic [1:0] PHASE_NORMAL  = 2'd0;
  localparam logic [1:0] PHASE_DISCARD = 2'd1;

  localparam logic [7:0] KANA_PREFIX = 8'h8e;

  logic [s2e_pkg::LIMIT_W-1:0] length_limit;
  logic [7:0]                  held_lead, held_lead_next;
  logic                        lead_pending, lead_pending_next;
  logic [s2e_pkg::LIMIT_W-1:0] emitted_count, emitted_count_next;
  logic [1:0]                  phase, phase_next;

  logic [7:0]                b;
  logic                      accept;
  logic [s2e_pkg::LIMIT_W:0] sum1, sum2, lim_ext;
  logic                      is_lead, is_kana, is_ascii;
  logic                      trail_hi;
  logic [7:0]                first, second, lead_sub, trail_add;

  assign src.ready = !q_full;
  assign accept    = src.valid && src.ready;
  assign b         = src.src_byte;

  assign lim_ext = {1'b0, length_limit};
  assign sum1    = {1'b0, emitted_count} + 17'd1;
  assign sum2    = {1'b0, emitted_count} + 17'd2;

  assign is_lead  = (b >= 8'h81 && b <= 8'h9f) || b >= 8'he0;
  assign is_kana  = b >= 8'ha0 && b <= 8'hdf;
  assign is_ascii = !b[7];

  // pair arithmetic, all modulo 256
  assign trail_hi  = b >= 8'h9f;
  assign lead_sub  = (held_lead >= 8'he0) ? (trail_hi ? 8'he0 : 8'he1)
                                          : (trail_hi ? 8'h60 : 8'h61);
  assign trail_add = trail_hi ? 8'h02 : ((b >= 8'h7f) ? 8'h60 : 8'h61);
  assign first     = {held_lead[6:0], 1'b0} - lead_sub;
  assign second    = b + trail_add;

  always_comb begin
    held_lead_next     = held_lead;
    lead_pending_next  = lead_pending;
    emitted_count_next = emitted_count;
    phase_next         = phase;
    push               = 1'b0;
    push_entry         = '0;
    if (accept) begin
      if (phase != PHASE_NORMAL) begin
        if (b == 8'h00) begin
          held_lead_next     = 8'h00;
          lead_pending_next  = 1'b0;
          emitted_count_next = '0;
          phase_next         = PHASE_NORMAL;
        end
      end else if (b == 8'h00) begin
        // terminator, also when a lead byte is left without its trail
        push               = 1'b1;
        push_entry.l0      = 1'b1;
        held_lead_next     = 8'h00;
        lead_pending_next  = 1'b0;
        emitted_count_next = '0;
      end else if (lead_pending) begin
        push               = 1'b1;
        push_entry.two     = 1'b1;
        push_entry.b0      = first;
        push_entry.b1      = second;
        emitted_count_next = emitted_count + 16'd2;
        lead_pending_next  = 1'b0;
        held_lead_next     = 8'h00;
      end else if (sum2 < lim_ext) begin
        if (is_lead) begin
          held_lead_next    = b;
          lead_pending_next = 1'b1;
        end else if (is_kana) begin
          push               = 1'b1;
          push_entry.two     = 1'b1;
          push_entry.b0      = KANA_PREFIX;
          push_entry.b1      = b;
          emitted_count_next = emitted_count + 16'd2;
        end else if (is_ascii) begin
          push               = 1'b1;
          push_entry.b0      = b;
          emitted_count_next = emitted_count + 16'd1;
        end
      end else begin
        // limit reached: maybe one last ascii byte, then the terminator
        push = 1'b1;
        if (is_ascii && sum1 < lim_ext) begin
          push_entry.two     = 1'b1;
          push_entry.b0      = b;
          push_entry.l1      = 1'b1;
          emitted_count_next = emitted_count + 16'd1;
        end else begin
          push_entry.l0 = 1'b1;
        end
        phase_next = PHASE_DISCARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit  <= s2e_pkg::LIMIT_RESET;
      held_lead     <= 8'h00;
      lead_pending  <= 1'b0;
      emitted_count <= '0;
      phase         <= PHASE_NORMAL;
    end else begin
      if (cfg_we) begin
        length_limit <= cfg_wdata;
      end
      held_lead     <= held_lead_next;
      lead_pending  <= lead_pending_next;
      emitted_count <= emitted_count_next;
      phase         <= phase_next;
    end
  end

endmodule

>>> hdl/s2e_queue.sv
`include "sjis_to_euc_stream_macros.svh"

module s2e_queue #(
  parameter int DEPTH = s2e_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  s2e_pkg::entry_t push_entry,
  output logic            full,
  output logic            q_valid,
  input  logic            q_ready,
  output s2e_pkg::entry_t q_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

  s2e_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   cnt;
  logic            push_fire, pop_fire;

  assign full      = cnt == DEPTH_C;
  assign q_valid   = cnt != '0;
  assign q_entry   = mem[rd_ptr];
  assign push_fire = push && !full;
  assign pop_fire  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        cnt <= cnt + 1'b1;
      end else if (pop_fire && !push_fire) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `S2E_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= DEPTH_C)
  `S2E_ASSERT_NXT(a_cnt_up, push_fire && !pop_fire, cnt == $past(cnt) + 1'b1)
  `S2E_ASSERT_NXT(a_cnt_down, pop_fire && !push_fire, cnt == $past(cnt) - 1'b1)

endmodule

>>> hdl/s2e_back.sv
`include "sjis_to_euc_stream_macros.svh"

module s2e_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  s2e_pkg::entry_t q_entry,
  s2e_out_if.source       dst
);

  s2e_pkg::entry_t cur;
  logic            valid;
  logic            sel;
  logic            fire, done;

  assign fire    = valid && dst.ready;
  assign done    = fire && (sel || !cur.two);
  assign q_ready = !valid || done;

  assign dst.valid    = valid;
  assign dst.out_byte = sel ? cur.b1 : cur.b0;
  assign dst.last     = sel ? cur.l1 : cur.l0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
    end else if (q_ready) begin
      valid <= q_valid;
      sel   <= 1'b0;
    end else if (fire) begin
      sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      cur <= q_entry;
    end
  end

  // second byte only exists for two-byte entries
  `S2E_ASSERT_IMP(a_sel_two, valid && sel, cur.two)
  // a finished entry never lingers when the queue has more
  `S2E_ASSERT_NXT(a_reload, done && q_valid, valid && !sel)

endmodule

>>> hdl/sjis_to_euc_stream.sv
// sjis_to_euc_stream: shift-jis byte stream in, euc-jp bytes out
// path: each converted entry is written into the queue, then loaded into the output
// register of the serialiser, from which its first result byte is offered
// throughput: one source byte per cycle while the queue has room; the output
// serialiser drains one byte per cycle while dst is ready, two-byte results byte by byte
// reset: synchronous, active high; clears the queue, count and phase, limit to 256
module sjis_to_euc_stream #(
  parameter int QUEUE_DEPTH = s2e_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  s2e_src_if.sink                     src,
  s2e_out_if.source                   dst,
  input  logic                        cfg_we,
  input  logic [s2e_pkg::LIMIT_W-1:0] cfg_wdata
);

  logic            q_full;
  logic            push;
  s2e_pkg::entry_t push_entry;
  logic            q_valid;
  logic            q_ready;
  s2e_pkg::entry_t q_entry;

  s2e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  s2e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry)
  );

  s2e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .dst     (dst)
  );

endmodule

>>> verif/sjis_to_euc_stream_tb.sv
`timescale 1ns / 1ps

module sjis_to_euc_stream_tb;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 6;
  localparam int ITEM_TARGET = 1600;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int STEADY_FROM = 800;
  localparam int STEADY_TO = 1100;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;

  localparam logic [7:0] NUL = 8'h00;
  localparam logic [7:0] KANA_PREFIX = 8'h8e;
  localparam logic [7:0] DROPPED_BYTE = 8'h80;

  typedef enum bit {PH_CONVERT, PH_DISCARD} conv_phase_t;
  typedef enum logic [1:0] {ROW_LIMIT, ROW_TYPED, ROW_PREDICT} row_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } euc_byte_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;
    int          n;
    logic [7:0]  b0;
    logic        l0;
    logic [7:0]  b1;
    logic        l1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [s2e_pkg::LIMIT_W-1:0] cfg_wdata = '0;

  s2e_src_if sjis_chan ();
  s2e_out_if euc_chan ();

  sjis_to_euc_stream dut (
    .clk       (clk),
    .rst       (rst),
    .src       (sjis_chan),
    .dst       (euc_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // converter state as predicted
  logic [15:0] length_limit = s2e_pkg::LIMIT_RESET;
  logic [7:0]  held_lead = '0;
  bit          lead_held = 1'b0;
  logic [15:0] emit_count = '0;
  conv_phase_t conv_phase = PH_CONVERT;

  euc_byte_t euc_pending[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  src_up = 1'b0;
  bit  steady = 1'b0;
  bit  hold_request = 1'b0;

  // source bytes with the expected bytes typed in where obvious
  stim_row_t directed_rows [28] = '{
    '{ROW_TYPED,   16'h41, 1, 8'h41, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h00, 1, 8'h00, 1'b1, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h80, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h7f, 1, 8'h7f, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'ha0, 2, 8'h8e, 1'b0, 8'ha0, 1'b0},
    '{ROW_TYPED,   16'hdf, 2, 8'h8e, 1'b0, 8'hdf, 1'b0},
    '{ROW_TYPED,   16'h81, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_PREDICT, 16'h40, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h9f, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_PREDICT, 16'h9f, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'he0, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_PREDICT, 16'h7f, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'hff, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_PREDICT, 16'hff, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h9f, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h00, 1, 8'h00, 1'b1, 8'h00, 1'b0},
    '{ROW_LIMIT,   16'd1,  0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h41, 1, 8'h00, 1'b1, 8'h00, 1'b0},
    '{ROW_TYPED,   16'hc3, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h00, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_LIMIT,   16'd2,  0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h41, 2, 8'h41, 1'b0, 8'h00, 1'b1},
    '{ROW_TYPED,   16'h00, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_LIMIT,   16'd3,  0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h8a, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_PREDICT, 16'h80, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h41, 1, 8'h00, 1'b1, 8'h00, 1'b0},
    '{ROW_TYPED,   16'h00, 0, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  function automatic void restart_string();
    held_lead = '0;
    lead_held = 1'b0;
    emit_count = '0;
    conv_phase = PH_CONVERT;
  endfunction

  // returns how many euc bytes one source byte gives, in r0 then r1
  function automatic int convert_sjis(input logic [7:0] b, output euc_byte_t r0,
                                      output euc_byte_t r1);
    int hi;
    int lo;
    int cnt;
    int lim;
    int n;
    r0 = '{NUL, 1'b0};
    r1 = '{NUL, 1'b0};
    hi = held_lead;
    lo = b;
    cnt = emit_count;
    lim = length_limit;
    if (conv_phase == PH_DISCARD) begin
      if (b == NUL) restart_string();
      return 0;
    end
    if (lead_held) begin
      if (b == NUL) begin
        r0 = '{NUL, 1'b1};
        restart_string();
        return 1;
      end
      if (lo >= 'h9f) begin
        r0.data = 8'(hi * 2 - (hi >= 'he0 ? 'he0 : 'h60));
        r1.data = 8'(lo + 2);
      end else begin
        r0.data = 8'(hi * 2 - (hi >= 'he0 ? 'he1 : 'h61));
        r1.data = 8'(lo + (lo >= 'h7f ? 'h60 : 'h61));
      end
      emit_count = emit_count + 16'd2;
      lead_held = 1'b0;
      held_lead = '0;
      return 2;
    end
    if (b == NUL) begin
      r0 = '{NUL, 1'b1};
      restart_string();
      return 1;
    end
    if (cnt + 2 < lim) begin
      if ((b >= 8'h81 && b <= 8'h9f) || b >= 8'he0) begin
        held_lead = b;
        lead_held = 1'b1;
        return 0;
      end
      if (b >= 8'ha0 && b <= 8'hdf) begin
        r0 = '{KANA_PREFIX, 1'b0};
        r1 = '{b, 1'b0};
        emit_count = emit_count + 16'd2;
        return 2;
      end
      if (!b[7]) begin
        r0 = '{b, 1'b0};
        emit_count = emit_count + 16'd1;
        return 1;
      end
      return 0;
    end
    // limit reached: maybe one last ascii byte, then the terminator
    n = 0;
    if (!b[7] && cnt + 1 < lim) begin
      r0 = '{b, 1'b0};
      emit_count = emit_count + 16'd1;
      n = 1;
    end
    if (n == 0) r0 = '{NUL, 1'b1};
    else r1 = '{NUL, 1'b1};
    conv_phase = PH_DISCARD;
    return n + 1;
  endfunction

  function automatic void queue_results(input int n, input euc_byte_t r0,
                                        input euc_byte_t r1);
    if (n >= 1) euc_pending.push_back(r0);
    if (n >= 2) euc_pending.push_back(r1);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  // returns at the edge where the request was taken
  task automatic offer_byte(input logic [7:0] b);
    sjis_chan.valid <= 1'b1;
    sjis_chan.src_byte <= b;
    src_up = 1'b1;
    do @(posedge clk); while (!sjis_chan.ready);
    items_sent++;
    steady = items_sent >= STEADY_FROM && items_sent < STEADY_TO;
    if (items_sent == HOLD_AT) hold_request = 1'b1;
  endtask

  task automatic maybe_pause();
    if (!steady && $urandom_range(99) < 30) begin
      sjis_chan.valid <= 1'b0;
      src_up = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic rest_source();
    if (src_up) begin
      sjis_chan.valid <= 1'b0;
      src_up = 1'b0;
    end
  endtask

  task automatic send_predicted(input logic [7:0] b);
    int n;
    euc_byte_t r0;
    euc_byte_t r1;
    offer_byte(b);
    n = convert_sjis(b, r0, r1);
    queue_results(n, r0, r1);
    maybe_pause();
  endtask

  // limit only changes once the converter has drained
  task automatic set_length_limit(input logic [15:0] v);
    rest_source();
    while (euc_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    length_limit = v;
  endtask

  task automatic send_string();
    int len;
    bit noisy;
    logic [7:0] lead;
    len = $urandom_range(0, 24);
    noisy = ($urandom_range(7) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        send_predicted(8'($urandom_range(1, 255)));
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: send_predicted(8'($urandom_range(1, 127)));
          4, 5: send_predicted(8'($urandom_range('ha0, 'hdf)));
          9: send_predicted(DROPPED_BYTE);
          default: begin
            lead = $urandom_range(1) ? 8'($urandom_range('h81, 'h9f))
                                     : 8'($urandom_range('he0, 'hff));
            send_predicted(lead);
            send_predicted($urandom_range(3) == 0 ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range('h40, 'hfc)));
          end
        endcase
      end
    end
    // now and then the string runs on past a limit change
    if ($urandom_range(5) != 0) send_predicted(NUL);
  endtask

  initial begin : stimulus
    int n;
    euc_byte_t r0;
    euc_byte_t r1;
    logic [15:0] next_limit;
    sjis_chan.valid = 1'b0;
    sjis_chan.src_byte = '0;
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LIMIT) begin
        set_length_limit(directed_rows[i].value);
      end else begin
        offer_byte(directed_rows[i].value[7:0]);
        n = convert_sjis(directed_rows[i].value[7:0], r0, r1);
        if (directed_rows[i].kind == ROW_TYPED) begin
          n = directed_rows[i].n;
          r0 = '{directed_rows[i].b0, directed_rows[i].l0};
          r1 = '{directed_rows[i].b1, directed_rows[i].l1};
        end
        queue_results(n, r0, r1);
        maybe_pause();
      end
    end

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: next_limit = 16'($urandom_range(1, 40));
        5: next_limit = 16'($urandom_range(1, 3));
        6: next_limit = 16'($urandom_range(41, 300));
        7: next_limit = 16'hffff;
        default: next_limit = 16'($urandom_range(1, 65535));
      endcase
      set_length_limit(next_limit);
      repeat ($urandom_range(1, 6)) send_string();
    end

    rest_source();
    while (euc_pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // output side: random back-pressure plus one long hold-off
  initial begin : euc_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    euc_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        euc_chan.ready <= 1'b0;
      end else begin
        euc_chan.ready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin : euc_check
    euc_byte_t want;
    if (!rst && euc_chan.valid && euc_chan.ready) begin
      if (euc_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  euc_chan.out_byte, euc_chan.last));
      end else begin
        want = euc_pending.pop_front();
        if (euc_chan.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", euc_chan.out_byte, want.data));
        if (euc_chan.last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", euc_chan.last, want.last));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((sjis_chan.valid && sjis_chan.ready) || (euc_chan.valid && euc_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request taken for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
